// ===== hdl/arpc_pkg.sv =====
`default_nettype none
package arpc_pkg;
    localparam int unsigned CacheEntriesDefault = 128;
    localparam logic [10:0] MIN_ARP_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;
    localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0] KIND_REPLY    = 2'd0;
    localparam logic [1:0] KIND_REQUEST  = 2'd1;
    localparam logic [1:0] KIND_RESOLVED = 2'd2;
    localparam logic [1:0] OPC_NONE    = 2'd0;
    localparam logic [1:0] OPC_REQUEST = 2'd1;
    localparam logic [1:0] OPC_REPLY   = 2'd2;
    localparam logic [1:0] CMD_REPLY  = 2'd0;
    localparam logic [1:0] CMD_LEARN  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] mac;
        logic [31:0] ip;
    } arpc_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/arp_responder_with_cache.sv =====
`default_nettype none
// ARP responder with an append-only IP/MAC cache. A received message that passes
// the header and target checks is queued: a request yields a reply and a
// reply is stored in the next free cache entry (dropped when full). A resolve
// query scans the cache one entry at a time through the registered RAM read,
// each entry passing through the ST_SCAN and ST_CMP states, and yields the
// first matching MAC or a broadcast request on a miss. A two-entry queue sits
// between the classifier and the cache engine. Registers: own_ip at 0x0,
// own_mac at 0x8 (64-bit data).
module arp_responder_with_cache import arpc_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = CacheEntriesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [10:0] payload_length,
    input  wire logic [15:0] hardware_type,
    input  wire logic [15:0] protocol_type,
    input  wire logic [7:0]  hw_addr_len,
    input  wire logic [7:0]  proto_addr_len,
    input  wire logic [15:0] opcode,
    input  wire logic [47:0] sender_mac_in,
    input  wire logic [31:0] sender_ip_in,
    input  wire logic [47:0] target_mac_in,
    input  wire logic [31:0] target_ip_in,
    input  wire logic [31:0] query_ip,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [1:0]       out_opcode,
    output logic [47:0]      out_sender_mac,
    output logic [31:0]      out_sender_ip,
    output logic [47:0]      out_target_mac,
    output logic [31:0]      out_target_ip,
    output logic [47:0]      resolved_mac
);
    localparam logic [3:0] ADDR_OWN_IP  = 4'h0;
    localparam logic [3:0] ADDR_OWN_MAC = 4'h8;

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic        q_valid, q_pop, wr;
    arpc_cmd_t   q_cmd;
    logic        unused_tmac;

    assign unused_tmac = ^target_mac_in;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr == ADDR_OWN_IP)
            begin
                own_ip_reg <= pwdata[31:0];
            end
            else if (paddr == ADDR_OWN_MAC)
            begin
                own_mac_reg <= pwdata[47:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_OWN_IP:  prdata = {32'd0, own_ip_reg} | {63'd0, unused_tmac & 1'b0};
            ADDR_OWN_MAC: prdata = {16'd0, own_mac_reg};
            default:      prdata = '0;
        endcase
    end

    arpc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .payload_length(payload_length), .hardware_type(hardware_type),
        .protocol_type(protocol_type), .hw_addr_len(hw_addr_len),
        .proto_addr_len(proto_addr_len), .opcode(opcode),
        .sender_mac_in(sender_mac_in), .sender_ip_in(sender_ip_in),
        .target_ip_in(target_ip_in), .query_ip(query_ip), .own_ip(own_ip_reg),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

    arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .own_ip(own_ip_reg), .own_mac(own_mac_reg),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .out_opcode(out_opcode), .out_sender_mac(out_sender_mac),
        .out_sender_ip(out_sender_ip), .out_target_mac(out_target_mac),
        .out_target_ip(out_target_ip), .resolved_mac(resolved_mac));
endmodule
`default_nettype wire

// ===== hdl/arpc_ram.sv =====
`default_nettype none
module arpc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/arpc_front.sv =====
`default_nettype none
module arpc_front import arpc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [10:0] payload_length,
    input  wire logic [15:0] hardware_type,
    input  wire logic [15:0] protocol_type,
    input  wire logic [7:0]  hw_addr_len,
    input  wire logic [7:0]  proto_addr_len,
    input  wire logic [15:0] opcode,
    input  wire logic [47:0] sender_mac_in,
    input  wire logic [31:0] sender_ip_in,
    input  wire logic [31:0] target_ip_in,
    input  wire logic [31:0] query_ip,
    input  wire logic [31:0] own_ip,
    output logic             q_valid,
    output arpc_cmd_t        q_cmd,
    input  wire logic        q_pop
);
    // Two-entry queue between classification and execution.
    arpc_cmd_t  fifo_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       ok, push;
    arpc_cmd_t  cmd;

    assign in_stall = (cnt_reg == 2'd2);

    always_comb
    begin
        ok = (payload_length >= MIN_ARP_LEN) && (hardware_type == HW_ETHERNET)
            && (protocol_type == PROTO_IPV4) && (hw_addr_len == 8'd6)
            && (proto_addr_len == 8'd4) && (target_ip_in == own_ip);
        cmd.mac = sender_mac_in;
        cmd.ip  = func ? query_ip : sender_ip_in;
        cmd.cmd = func ? CMD_QUERY : ((opcode == OP_REQUEST) ? CMD_REPLY : CMD_LEARN);
        push = in_valid && !in_stall
            && (func || (ok && (opcode == OP_REQUEST || opcode == OP_REPLY)));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];
endmodule
`default_nettype wire

// ===== hdl/arpc_back.sv =====
`default_nettype none
module arpc_back import arpc_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = CacheEntriesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire arpc_cmd_t   q_cmd,
    output logic             q_pop,
    input  wire logic [31:0] own_ip,
    input  wire logic [47:0] own_mac,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [1:0]       out_opcode,
    output logic [47:0]      out_sender_mac,
    output logic [31:0]      out_sender_ip,
    output logic [47:0]      out_target_mac,
    output logic [31:0]      out_target_ip,
    output logic [47:0]      resolved_mac
);
    localparam int unsigned AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(CACHE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   qip_reg, qip_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    kind_reg, kind_next, opc_reg, opc_next;
    logic [47:0]   smac_reg, smac_next, tmac_reg, tmac_next, rmac_reg, rmac_next;
    logic [31:0]   sip_reg, sip_next, tip_reg, tip_next;
    logic          we;
    logic [AW-1:0] raddr;
    logic [31:0]   ip_rd;
    logic [47:0]   mac_rd;
    logic          out_free;

    arpc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_ip_ram (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(q_cmd.ip),
        .raddr(raddr), .rdata(ip_rd));
    arpc_ram #(.WIDTH(48), .DEPTH(CACHE_ENTRIES)) u_mac_ram (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(q_cmd.mac),
        .raddr(raddr), .rdata(mac_rd));

    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        qip_next    = qip_reg;
        ovalid_next = ovalid_reg && out_stall;
        kind_next = kind_reg; opc_next = opc_reg; smac_next = smac_reg;
        sip_next = sip_reg; tmac_next = tmac_reg; tip_next = tip_reg;
        rmac_next = rmac_reg;
        q_pop = 1'b0;
        we    = 1'b0;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.cmd)
                        CMD_LEARN:
                        begin
                            q_pop = 1'b1;
                            if (count_reg != FULL)
                            begin
                                we = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_REPLY:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                ovalid_next = 1'b1;
                                kind_next = KIND_REPLY; opc_next = OPC_REPLY;
                                smac_next = own_mac; sip_next = own_ip;
                                tmac_next = q_cmd.mac; tip_next = q_cmd.ip;
                                rmac_next = '0;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                            qip_next = q_cmd.ip;
                            idx_next = '0;
                            raddr = '0;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Read for idx_reg was issued last cycle; data arrives now.
                if (idx_reg == count_reg)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        kind_next = KIND_REQUEST; opc_next = OPC_REQUEST;
                        smac_next = own_mac; sip_next = own_ip;
                        tmac_next = MAC_ALL_ONES; tip_next = qip_reg;
                        rmac_next = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (ip_rd == qip_reg)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        kind_next = KIND_RESOLVED; opc_next = OPC_NONE;
                        smac_next = '0; sip_next = '0; tmac_next = '0; tip_next = '0;
                        rmac_next = mac_rd;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    raddr = idx_next[AW-1:0];
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Hold the read address while waiting so ram data stays put.
        if (state_reg == ST_CMP && state_next == ST_CMP)
        begin
            raddr = idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; qip_reg <= qip_next;
        kind_reg <= kind_next; opc_reg <= opc_next; smac_reg <= smac_next;
        sip_reg <= sip_next; tmac_reg <= tmac_next; tip_reg <= tip_next;
        rmac_reg <= rmac_next;
    end

    assign out_valid      = ovalid_reg;
    assign kind           = kind_reg;
    assign out_opcode     = opc_reg;
    assign out_sender_mac = smac_reg;
    assign out_sender_ip  = sip_reg;
    assign out_target_mac = tmac_reg;
    assign out_target_ip  = tip_reg;
    assign resolved_mac   = rmac_reg;
endmodule
`default_nettype wire
